### src/bdq_pkg.sv
// Shared constants for the bounded deque: command and status codes, field and beat widths.
package bdq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int CMD_W   = 3;
    localparam int VALUE_W = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W = 5;

    // Beat widths: fields packed from bit 0 up, rounded to whole bytes.
    localparam int S_TDATA_W = ((CMD_W + VALUE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((STATUS_W + COUNT_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - STATUS_W - COUNT_W;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam cmd_t CMD_CLEAR      = 3'd0;
    localparam cmd_t CMD_PUSH_FRONT = 3'd1;
    localparam cmd_t CMD_PUSH_BACK  = 3'd2;
    localparam cmd_t CMD_POP_FRONT  = 3'd3;
    localparam cmd_t CMD_POP_BACK   = 3'd4;
    localparam cmd_t CMD_REMOVE     = 3'd5;
    localparam cmd_t CMD_FIND       = 3'd6;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_EMPTY = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

endpackage

### src/bounded_deque_with_value_removal.sv
// Top level of the bounded deque: a doubly linked list of signed values in a node pool.
//
// Usage: each input beat on the s_ channel carries one command (clear, push front,
// push back, pop front, pop back, remove first matching value, find value). Each
// command produces exactly one result beat on the m_ channel with a status
// (ok/found, empty/not found, full) and the entry count after the command.
// The node values and both link arrays sit in three small memories with one
// write and one registered read port each; a small sequencer drives them.
// Flow: s_tready is high only while the sequencer is idle and
// the result register is free or being emptied, so one command is in flight at
// a time. Clear, invalid codes, refused pushes and pops, removes or finds on an
// empty list finish on the accepting edge. A pop does one link read and then one
// unlink write. A push scans for a free node, which looks at one node flag per
// cycle, then writes the new node and, unless the list was empty, links the old
// end node to it. A find or remove walks from the head, as the walk issues one
// memory read per cycle, and a remove then unlinks the match.
// Reset (aresetn low, synchronous) empties the list and the result register;
// the memories are not cleared, as no entry is read before it is written.
// A stalled receiver holds the result beat steady and blocks new commands.

module bounded_deque_with_value_removal #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata from bit 0 up: cmd[2:0], item_value[34:3], zero padding.
    input  logic [bdq_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata from bit 0 up: status[1:0], entry_count[6:2], zero padding.
    output logic [bdq_pkg::M_TDATA_W-1:0]  m_tdata
);
    import bdq_pkg::*;

    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LINK_W = $clog2(DEPTH + 1);
    localparam int LEN_W  = $clog2(DEPTH + 1);
    localparam int EXT_W  = (LEN_W > COUNT_W) ? LEN_W : COUNT_W;
    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(DEPTH);
    localparam logic [LEN_W-1:0]  LEN_FULL  = LEN_W'(DEPTH);
    localparam logic [IDX_W-1:0]  LAST_STEP = IDX_W'(DEPTH - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_PUSHW  = 3'd2;
    localparam logic [2:0] ST_PUSHL  = 3'd3;
    localparam logic [2:0] ST_WALK   = 3'd4;
    localparam logic [2:0] ST_UNLINK = 3'd5;

    function automatic logic link_ok(input logic [LINK_W-1:0] l);
        return l < LINK_NONE;
    endfunction

    // Node pool memories.
    logic signed [VALUE_W-1:0] node_val_mem [DEPTH];
    logic [LINK_W-1:0]         next_mem     [DEPTH];
    logic [LINK_W-1:0]         prev_mem     [DEPTH];

    logic [2:0]                state_reg, state_next;
    cmd_t                      cmd_reg, cmd_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic [IDX_W-1:0]          node_reg, node_next;
    logic [IDX_W-1:0]          steps_reg, steps_next;
    logic [DEPTH-1:0]          in_use_reg, in_use_next;
    logic [LINK_W-1:0]         head_reg, head_next;
    logic [LINK_W-1:0]         tail_reg, tail_next;
    logic [LEN_W-1:0]          len_reg, len_next;
    logic                      m_valid_reg, m_valid_next;
    status_t                   m_status_reg, m_status_next;
    logic [COUNT_W-1:0]        m_count_reg, m_count_next;

    // Memory ports.
    logic                      rd_en;
    logic [IDX_W-1:0]          rd_addr;
    logic signed [VALUE_W-1:0] rd_val_reg;
    logic [LINK_W-1:0]         rd_next_reg, rd_prev_reg;
    logic                      val_we, next_we, prev_we;
    logic [IDX_W-1:0]          val_waddr, next_waddr, prev_waddr;
    logic [LINK_W-1:0]         next_wdata, prev_wdata;

    logic                      s_accept;
    cmd_t                      s_cmd;
    logic signed [VALUE_W-1:0] s_value;
    logic                      finish;
    status_t                   fin_status;
    logic [LINK_W-1:0]         node_link;
    logic [LINK_W-1:0]         pop_node;
    logic [EXT_W-1:0]          len_ext;

    assign s_tready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign s_accept  = s_tvalid && s_tready;
    assign s_cmd     = s_tdata[CMD_W-1:0];
    assign s_value   = s_tdata[CMD_W+VALUE_W-1:CMD_W];
    assign node_link = LINK_W'(node_reg);
    assign pop_node  = (s_cmd == CMD_POP_FRONT) ? head_reg : tail_reg;
    assign len_ext   = EXT_W'(len_next);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_count_reg, m_status_reg};

    always_comb begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        val_next    = val_reg;
        node_next   = node_reg;
        steps_next  = steps_reg;
        in_use_next = in_use_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        len_next    = len_reg;
        finish      = 1'b0;
        fin_status  = STATUS_OK;
        rd_en       = 1'b0;
        rd_addr     = node_reg;
        val_we      = 1'b0;
        val_waddr   = node_reg;
        next_we     = 1'b0;
        next_waddr  = node_reg;
        next_wdata  = LINK_NONE;
        prev_we     = 1'b0;
        prev_waddr  = node_reg;
        prev_wdata  = LINK_NONE;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    cmd_next   = s_cmd;
                    val_next   = s_value;
                    node_next  = '0;
                    steps_next = '0;
                    unique case (s_cmd) inside
                        CMD_CLEAR: begin
                            in_use_next = '0;
                            head_next   = LINK_NONE;
                            tail_next   = LINK_NONE;
                            len_next    = '0;
                            finish      = 1'b1;
                        end
                        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                            if (len_reg >= LEN_FULL) begin
                                finish     = 1'b1;
                                fin_status = STATUS_FULL;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK: begin
                            if (link_ok(pop_node) && (len_reg != '0)) begin
                                rd_en      = 1'b1;
                                rd_addr    = pop_node[IDX_W-1:0];
                                node_next  = pop_node[IDX_W-1:0];
                                state_next = ST_UNLINK;
                            end else begin
                                finish     = 1'b1;
                                fin_status = STATUS_EMPTY;
                            end
                        end
                        CMD_REMOVE, CMD_FIND: begin
                            if (link_ok(head_reg)) begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg[IDX_W-1:0];
                                node_next  = head_reg[IDX_W-1:0];
                                state_next = ST_WALK;
                            end else begin
                                finish     = 1'b1;
                                fin_status = STATUS_EMPTY;
                            end
                        end
                        default: begin
                            finish     = 1'b1;
                            fin_status = STATUS_EMPTY;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // One node flag per cycle; a free node exists since the list is not full.
                if (!in_use_reg[node_reg]) begin
                    in_use_next[node_reg] = 1'b1;
                    state_next = ST_PUSHW;
                end else begin
                    node_next = IDX_W'(node_reg + 1'b1);
                end
            end
            ST_PUSHW: begin
                val_we = 1'b1;
                next_we = 1'b1;
                prev_we = 1'b1;
                if (cmd_reg == CMD_PUSH_FRONT) begin
                    prev_wdata = LINK_NONE;
                    next_wdata = head_reg;
                    if (link_ok(head_reg)) begin
                        state_next = ST_PUSHL;
                    end else begin
                        head_next  = node_link;
                        tail_next  = node_link;
                        len_next   = LEN_W'(len_reg + 1'b1);
                        finish     = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    next_wdata = LINK_NONE;
                    prev_wdata = tail_reg;
                    if (link_ok(tail_reg)) begin
                        state_next = ST_PUSHL;
                    end else begin
                        head_next  = node_link;
                        tail_next  = node_link;
                        len_next   = LEN_W'(len_reg + 1'b1);
                        finish     = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PUSHL: begin
                // Back-link the old end node to the new one.
                if (cmd_reg == CMD_PUSH_FRONT) begin
                    prev_we    = 1'b1;
                    prev_waddr = head_reg[IDX_W-1:0];
                    prev_wdata = node_link;
                    head_next  = node_link;
                end else begin
                    next_we    = 1'b1;
                    next_waddr = tail_reg[IDX_W-1:0];
                    next_wdata = node_link;
                    tail_next  = node_link;
                end
                len_next   = LEN_W'(len_reg + 1'b1);
                finish     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_WALK: begin
                // The registered read holds node_reg's value and links.
                if (rd_val_reg == val_reg) begin
                    if (cmd_reg == CMD_FIND) begin
                        finish     = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_UNLINK;
                    end
                end else if (link_ok(rd_next_reg) && (steps_reg != LAST_STEP)) begin
                    rd_en      = 1'b1;
                    rd_addr    = rd_next_reg[IDX_W-1:0];
                    node_next  = rd_next_reg[IDX_W-1:0];
                    steps_next = IDX_W'(steps_reg + 1'b1);
                end else begin
                    finish     = 1'b1;
                    fin_status = STATUS_EMPTY;
                    state_next = ST_IDLE;
                end
            end
            ST_UNLINK: begin
                if (link_ok(rd_prev_reg)) begin
                    next_we    = 1'b1;
                    next_waddr = rd_prev_reg[IDX_W-1:0];
                    next_wdata = rd_next_reg;
                end else begin
                    head_next = link_ok(rd_next_reg) ? rd_next_reg : LINK_NONE;
                end
                if (link_ok(rd_next_reg)) begin
                    prev_we    = 1'b1;
                    prev_waddr = rd_next_reg[IDX_W-1:0];
                    prev_wdata = rd_prev_reg;
                end else begin
                    tail_next = link_ok(rd_prev_reg) ? rd_prev_reg : LINK_NONE;
                end
                in_use_next[node_reg] = 1'b0;
                if (len_reg != '0) begin
                    len_next = LEN_W'(len_reg - 1'b1);
                end
                finish     = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_count_next  = m_count_reg;
        if (finish) begin
            m_valid_next  = 1'b1;
            m_status_next = fin_status;
            m_count_next  = len_ext[COUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            in_use_reg  <= '0;
            head_reg    <= LINK_NONE;
            tail_reg    <= LINK_NONE;
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            in_use_reg  <= in_use_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            len_reg     <= len_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        val_reg      <= val_next;
        node_reg     <= node_next;
        steps_reg    <= steps_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
    end

    // Node pool: one write port per array, one shared registered read address.
    always_ff @(posedge aclk) begin
        if (val_we) begin
            node_val_mem[val_waddr] <= val_reg;
        end
        if (next_we) begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (prev_we) begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (rd_en) begin
            rd_val_reg  <= node_val_mem[rd_addr];
            rd_next_reg <= next_mem[rd_addr];
            rd_prev_reg <= prev_mem[rd_addr];
        end
    end

    // Between commands the node flags agree with the entry count. A push claims its
    // node in the scan state before it counts it, so the check waits for the idle state.
    a_count_matches_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (32'($countones(in_use_reg)) == 32'(len_reg)))
        else $error("node flags disagree with entry count");

    // The list has a head exactly when it is not empty.
    a_head_iff_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg == LINK_NONE) == (len_reg == '0))
        else $error("head pointer disagrees with entry count");

    a_len_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_FULL)
        else $error("entry count beyond capacity");

    // A clear answers on the next cycle with an empty list.
    a_clear_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_cmd == CMD_CLEAR) |=>
            (m_valid_reg && len_reg == '0 && m_status_reg == STATUS_OK))
        else $error("clear did not produce an empty result");

endmodule

### dv/bounded_deque_with_value_removal_checker.sv
`timescale 1ns / 1ps
// Checker for the bounded deque: keeps its own linked-list copy, predicts each result beat and compares.
module bounded_deque_with_value_removal_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [bdq_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [bdq_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            fail_count,
    output int                            pending,
    output int                            results_seen,
    output int                            refused_pushes,
    output int                            misses
);
    import bdq_pkg::*;

    localparam int NODES  = DEPTH_DEFAULT;
    localparam int LINK_W = $clog2(NODES + 1);

    typedef logic [LINK_W-1:0] link_t;
    localparam link_t NO_LINK = link_t'(NODES);

    typedef struct {
        cmd_t               cmd;
        status_t            status;
        logic [COUNT_W-1:0] count;
    } outcome_t;

    // Shadow copy of the node pool and the list ends.
    logic [VALUE_W-1:0] pool_value [NODES];
    link_t              pool_next  [NODES];
    link_t              pool_prev  [NODES];
    logic [NODES-1:0]   pool_busy;
    link_t              first_node;
    link_t              last_node;
    logic [COUNT_W-1:0] n_entries;

    outcome_t outcome_q [$];

    function automatic bit is_link(input link_t i);
        return i < NODES;
    endfunction

    function automatic void empty_deque();
        pool_busy  = '0;
        first_node = NO_LINK;
        last_node  = NO_LINK;
        n_entries  = '0;
    endfunction

    // Walk from the front, at most one pass over the pool.
    function automatic link_t locate(input logic [VALUE_W-1:0] v);
        link_t p;
        int    steps;
        p = first_node;
        for (steps = 0; steps < NODES && is_link(p); steps++) begin
            if (pool_value[p] == v) begin
                return p;
            end
            p = pool_next[p];
        end
        return NO_LINK;
    endfunction

    function automatic void unhook(input link_t n);
        link_t pv;
        link_t nx;
        pv = pool_prev[n];
        nx = pool_next[n];
        if (is_link(pv)) begin
            pool_next[pv] = nx;
        end else begin
            first_node = is_link(nx) ? nx : NO_LINK;
        end
        if (is_link(nx)) begin
            pool_prev[nx] = pv;
        end else begin
            last_node = is_link(pv) ? pv : NO_LINK;
        end
        pool_busy[n] = 1'b0;
        if (n_entries > 0) begin
            n_entries--;
        end
    endfunction

    // A push always takes the free node with the lowest index.
    function automatic status_t insert(input bit at_front, input logic [VALUE_W-1:0] v);
        link_t n;
        int    i;
        n = NO_LINK;
        if (n_entries >= NODES) begin
            return STATUS_FULL;
        end
        for (i = NODES - 1; i >= 0; i--) begin
            if (!pool_busy[i]) begin
                n = link_t'(i);
            end
        end
        if (!is_link(n)) begin
            return STATUS_FULL;
        end
        pool_busy[n]  = 1'b1;
        pool_value[n] = v;
        if (at_front) begin
            pool_prev[n] = NO_LINK;
            pool_next[n] = first_node;
            if (is_link(first_node)) begin
                pool_prev[first_node] = n;
            end else begin
                last_node = n;
            end
            first_node = n;
        end else begin
            pool_next[n] = NO_LINK;
            pool_prev[n] = last_node;
            if (is_link(last_node)) begin
                pool_next[last_node] = n;
            end else begin
                first_node = n;
            end
            last_node = n;
        end
        n_entries++;
        return STATUS_OK;
    endfunction

    function automatic status_t deque_apply(input cmd_t c, input logic [VALUE_W-1:0] v);
        link_t   n;
        status_t st;
        st = STATUS_OK;
        case (c) inside
            CMD_CLEAR: begin
                empty_deque();
            end
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                st = insert(c == CMD_PUSH_FRONT, v);
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                n = (c == CMD_POP_FRONT) ? first_node : last_node;
                if (is_link(n) && n_entries > 0) begin
                    unhook(n);
                end else begin
                    st = STATUS_EMPTY;
                end
            end
            CMD_REMOVE: begin
                n = locate(v);
                if (is_link(n)) begin
                    unhook(n);
                end else begin
                    st = STATUS_EMPTY;
                end
            end
            CMD_FIND: begin
                st = is_link(locate(v)) ? STATUS_OK : STATUS_EMPTY;
            end
            default: begin
                st = STATUS_EMPTY;
            end
        endcase
        return st;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] deque checker: %s", $time, msg);
        fail_count++;
    endtask

    // Commands are predicted before results are checked, so a result landing on the
    // same edge as a new command still meets the older expectation first.
    always @(posedge aclk) begin
        outcome_t           want;
        status_t            got_status;
        logic [COUNT_W-1:0] got_count;
        if (!aresetn) begin
            empty_deque();
            outcome_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                want.cmd    = s_tdata[CMD_W-1:0];
                want.status = deque_apply(want.cmd, s_tdata[CMD_W +: VALUE_W]);
                want.count  = n_entries;
                if (want.status == STATUS_FULL) begin
                    refused_pushes++;
                end
                if (want.status == STATUS_EMPTY) begin
                    misses++;
                end
                outcome_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got_status = m_tdata[STATUS_W-1:0];
                got_count  = m_tdata[STATUS_W +: COUNT_W];
                results_seen++;
                if (outcome_q.size() == 0) begin
                    report_mismatch($sformatf("result beat 0x%h with no command waiting",
                                              m_tdata));
                end else begin
                    want = outcome_q.pop_front();
                    if (got_status !== want.status) begin
                        report_mismatch($sformatf("cmd %0d: status %0d, predicted %0d",
                                                  want.cmd, got_status, want.status));
                    end
                    if (got_count !== want.count) begin
                        report_mismatch($sformatf("cmd %0d: entry_count %0d, predicted %0d",
                                                  want.cmd, got_count, want.count));
                    end
                end
            end
        end
        pending = outcome_q.size();
    end

endmodule

### dv/bounded_deque_with_value_removal_test.sv
`timescale 1ns / 1ps
// Testbench top for the bounded deque: clock, reset, command stimulus, idling and the verdict.
module bounded_deque_with_value_removal_test;
    import bdq_pkg::*;

    // Code 7 is not a command; the block must answer it with an error status.
    localparam cmd_t CMD_UNUSED = 3'd7;

    localparam int NODES        = DEPTH_DEFAULT;
    localparam int TOTAL_ITEMS  = 950;
    // The final stretch of the run goes without any idling on either side.
    localparam int CALM_ITEMS   = 120;
    // Random commands come in phases; each phase picks a command mix and idling levels.
    localparam int PHASE_LEN    = 48;
    // The limit leaves a wide margin over the longest command, a push that scans all
    // 16 node flags and links its node, plus a sender gap and a receiver stall.
    localparam int QUIET_LIMIT  = 200;
    localparam int DRAIN_CYCLES = 25;
    localparam int S_PAD_W      = S_TDATA_W - CMD_W - VALUE_W;

    // Mixes of random commands: mostly pushes, mostly pops and removals, or balanced.
    typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    // s_tdata from bit 0 up: cmd, item_value, zero padding.
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b1;
    // m_tdata from bit 0 up: status, entry_count, zero padding.
    logic [M_TDATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int results_seen;
    int refused_pushes;
    int misses;

    int sent;
    int gap_pct;
    int stall_pct;
    int stall_left;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    bounded_deque_with_value_removal #(
        .DEPTH(NODES)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    bounded_deque_with_value_removal_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen),
        .refused_pushes(refused_pushes),
        .misses        (misses)
    );

    // Receiver back-pressure. Each stall ends with ready raised again before another
    // can start, so bursts never merge into longer ones.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
                stall_left = $urandom_range(3, 1);
            end
        end
    end

    // Ends the run if no beat moves on either channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Presents one command beat, possibly after a short gap, and returns at the
    // falling edge after it was taken. Valid stays high when no gap follows, so it
    // is never lowered and raised within the same step.
    task automatic send_beat(input cmd_t cmd, input logic [VALUE_W-1:0] value);
        int gap;
        gap = ($urandom_range(99) < gap_pct) ? $urandom_range(3, 1) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{S_PAD_W{1'b0}}, value, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
        @(negedge aclk);
    endtask

    function automatic int pick_idle_pct();
        case ($urandom_range(2))
            0: return 0;
            1: return 15;
            default: return 40;
        endcase
    endfunction

    // Half the values come from a tiny signed range, so finds and removals hit and
    // duplicates pile up; the rest are extremes or fully random words.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] near_zero;
        int                 r;
        r = $urandom_range(9);
        if (r < 5) begin
            near_zero = $urandom_range(7);
            return near_zero - 4;
        end
        if (r < 7) begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        return $urandom();
    endfunction

    function automatic cmd_t pick_command(input mix_t mix);
        int r;
        int push_pct;
        push_pct = (mix == MIX_FILL) ? 75 : (mix == MIX_DRAIN) ? 18 : 42;
        r = $urandom_range(99);
        if (r < 1) begin
            return CMD_CLEAR;
        end
        if (r < 2) begin
            return CMD_UNUSED;
        end
        if (r < 2 + push_pct) begin
            return $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        end
        case ($urandom_range(3))
            0: return CMD_POP_FRONT;
            1: return CMD_POP_BACK;
            2: return CMD_REMOVE;
            default: return CMD_FIND;
        endcase
    endfunction

    initial begin
        logic [VALUE_W-1:0] fill_vals [NODES];
        mix_t               mix;
        int                 phase_left;
        int                 i;

        // Sixteen values to fill the pool. The value 5 appears twice, once pushed at
        // the front and once at the back, so a removal must take the front copy.
        fill_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                      32'haaaa_aaaa, 32'h0000_0001, 32'h0000_0005, 32'h1234_5678,
                      32'hffff_fffe, 32'h4000_0000, 32'h0000_0100, 32'h0000_0005,
                      32'hc000_0000, 32'h0000_ffff, 32'h7fff_fffe, 32'h8000_0001};
        mix        = MIX_EVEN;
        phase_left = 0;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, with light idling on both sides.
        gap_pct   = 15;
        stall_pct = 15;
        // Commands on an empty list: clear, pop, remove, and the unused code.
        send_beat(CMD_CLEAR, 32'h0000_0000);
        send_beat(CMD_POP_FRONT, 32'h0000_0000);
        send_beat(CMD_REMOVE, 32'h0000_0000);
        send_beat(CMD_UNUSED, 32'hffff_ffff);
        // Fill the pool from both ends, then push once more onto the full list.
        for (i = 0; i < NODES; i++) begin
            send_beat(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, fill_vals[i]);
        end
        send_beat(CMD_PUSH_FRONT, 32'h0000_0001);
        // Find a present and an absent value, remove the duplicate and a missing value.
        send_beat(CMD_FIND, 32'h7fff_ffff);
        send_beat(CMD_FIND, 32'h5555_5555);
        send_beat(CMD_REMOVE, 32'h0000_0005);
        send_beat(CMD_REMOVE, 32'h5555_5555);
        send_beat(CMD_POP_FRONT, 32'h0000_0000);
        send_beat(CMD_POP_BACK, 32'h0000_0000);

        // Random part. Each phase drifts the list toward full, toward empty, or
        // keeps it balanced, so pushes meet a full pool and pops an empty one often.
        while (sent < TOTAL_ITEMS) begin
            if (phase_left == 0) begin
                mix        = mix_t'($urandom_range(2));
                gap_pct    = pick_idle_pct();
                stall_pct  = pick_idle_pct();
                phase_left = PHASE_LEN;
            end
            phase_left--;
            if (sent >= TOTAL_ITEMS - CALM_ITEMS) begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            send_beat(pick_command(mix), pick_value());
        end
        s_tvalid <= 1'b0;

        // Let every predicted result arrive, then watch a little longer for strays.
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Summary: %0d commands sent, %0d result beats checked against the prediction.",
                 sent, results_seen);
        $display("Summary: %0d pushes refused on a full list, %0d empty or unmatched outcomes.",
                 refused_pushes, misses);
        if (pending != 0) begin
            $display("%0d predicted results never arrived", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
